// ===== hw/rtl/tdgw_pkg.sv =====
// tdgw_pkg: shared types and constants for the tick divider with gate window
// holds transaction structs, item kind codes, gate states and flag bit indexes
// no dependencies
package tdgw_pkg;

  localparam logic [3:0] TICKS_PER_TENTH   = 4'd10;
  localparam logic [3:0] TENTHS_PER_SECOND = 4'd10;

  // item kind codes; code 3 is unused and leaves the state alone
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // bit positions in the sticky flag register
  localparam int FLAG_10MS_BIT  = 0;
  localparam int FLAG_100MS_BIT = 1;
  localparam int FLAG_1S_BIT    = 2;
  localparam int FLAG_DONE_BIT  = 3;

  typedef enum logic [1:0] {
    GATE_OFF      = 2'd0,
    GATE_ARMED    = 2'd1,
    GATE_SAMPLING = 2'd2,
    GATE_DONE     = 2'd3
  } gate_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] period;
    logic [3:0] clear_mask;
  } item_t;

  typedef struct packed {
    logic [15:0] tick_count;
    logic        flag_10ms;
    logic        flag_100ms;
    logic        flag_1s;
    logic        flag_complete;
    logic        start_pulse;
    logic        stop_pulse;
    logic        gate_level;
    logic [1:0]  window_state;
  } result_t;

endpackage

// ===== hw/rtl/tick_divider_with_gate_window.sv =====
// tick_divider_with_gate_window: top level of the timebase with gate window
// instantiates tdgw_core and tdgw_out; depends on tdgw_pkg
//
//   channel  | signals                          | direction | payload
//   item     | item_valid, item_ready, item     | in        | item_t
//   result   | result_valid, result_ready, result | out     | result_t
//
// each transaction is applied when accepted; its result shows in the result
// register on the next cycle, and one transaction per cycle is sustained while result_ready stays high
// reset zeroes the tick count and flags, reloads the dividers, turns the gate off and empties the result register
// a stalled result holds item_ready low only while the full result register waits
module tick_divider_with_gate_window
  import tdgw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic    accept;
  result_t result_next;

  assign accept = item_valid && item_ready;

  tdgw_core u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .result_next (result_next)
  );

  tdgw_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .result_next  (result_next),
    .can_load     (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hw/rtl/tdgw_core.sv =====
// tdgw_core: timebase state registers and their single-pass update logic
// computes the post-item state and result from the incoming transaction
// depends on tdgw_pkg
module tdgw_core
  import tdgw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    accept,
  input  item_t   item,
  output result_t result_next
);

  logic [15:0] tick_total;
  logic [3:0]  tenth_counter;
  logic [3:0]  second_counter;
  gate_state_t gate_state;
  logic [7:0]  remaining_ticks;
  logic [3:0]  event_flags;
  logic        gate_pin;

  logic [15:0] tick_total_next;
  logic [3:0]  tenth_counter_next;
  logic [3:0]  second_counter_next;
  gate_state_t gate_state_next;
  logic [7:0]  remaining_ticks_next;
  logic [3:0]  event_flags_next;
  logic        gate_pin_next;

  logic        is_tick;
  logic        is_start;
  logic        is_clear;
  logic [7:0]  remaining_dec;
  logic [3:0]  tenth_dec;
  logic [3:0]  second_dec;
  logic        start_pulse;
  logic        stop_pulse;

  assign is_tick  = (item.kind == KIND_TICK);
  assign is_start = (item.kind == KIND_START);
  assign is_clear = (item.kind == KIND_CLEAR);

  assign remaining_dec = remaining_ticks - 8'd1;
  assign tenth_dec     = tenth_counter - 4'd1;
  assign second_dec    = second_counter - 4'd1;

  // gate window next state
  always_comb begin
    gate_state_next = gate_state;
    if (is_start) begin
      gate_state_next = GATE_ARMED;
    end else if (is_tick) begin
      case (gate_state)
        GATE_ARMED:    gate_state_next = GATE_SAMPLING;
        GATE_SAMPLING: if (remaining_dec == 8'd0) gate_state_next = GATE_DONE;
        default:       gate_state_next = gate_state;
      endcase
    end
  end

  // gate window outputs and window counter
  always_comb begin
    start_pulse          = 1'b0;
    stop_pulse           = 1'b0;
    gate_pin_next        = gate_pin;
    remaining_ticks_next = remaining_ticks;
    if (is_start) begin
      remaining_ticks_next = item.period;
    end else if (is_tick) begin
      case (gate_state)
        GATE_ARMED: begin
          gate_pin_next = 1'b1;
          start_pulse   = 1'b1;
        end
        GATE_SAMPLING: begin
          remaining_ticks_next = remaining_dec;
          if (remaining_dec == 8'd0) begin
            gate_pin_next = 1'b0;
            stop_pulse    = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // tick count, cascaded dividers and sticky flags
  always_comb begin
    tick_total_next     = tick_total;
    tenth_counter_next  = tenth_counter;
    second_counter_next = second_counter;
    event_flags_next    = event_flags;
    if (is_tick) begin
      tick_total_next = tick_total + 16'd1;
      event_flags_next[FLAG_10MS_BIT] = 1'b1;
      if (stop_pulse) event_flags_next[FLAG_DONE_BIT] = 1'b1;
      tenth_counter_next = tenth_dec;
      if (tenth_dec == 4'd0) begin
        tenth_counter_next = TICKS_PER_TENTH;
        event_flags_next[FLAG_100MS_BIT] = 1'b1;
        second_counter_next = second_dec;
        if (second_dec == 4'd0) begin
          second_counter_next = TENTHS_PER_SECOND;
          event_flags_next[FLAG_1S_BIT] = 1'b1;
        end
      end
    end else if (is_start) begin
      event_flags_next[FLAG_DONE_BIT] = 1'b0;
    end else if (is_clear) begin
      event_flags_next = event_flags & ~item.clear_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total      <= '0;
      tenth_counter   <= TICKS_PER_TENTH;
      second_counter  <= TENTHS_PER_SECOND;
      gate_state      <= GATE_OFF;
      remaining_ticks <= '0;
      event_flags     <= '0;
      gate_pin        <= 1'b0;
    end else if (accept) begin
      tick_total      <= tick_total_next;
      tenth_counter   <= tenth_counter_next;
      second_counter  <= second_counter_next;
      gate_state      <= gate_state_next;
      remaining_ticks <= remaining_ticks_next;
      event_flags     <= event_flags_next;
      gate_pin        <= gate_pin_next;
    end
  end

  always_comb begin
    result_next.tick_count    = tick_total_next;
    result_next.flag_10ms     = event_flags_next[FLAG_10MS_BIT];
    result_next.flag_100ms    = event_flags_next[FLAG_100MS_BIT];
    result_next.flag_1s       = event_flags_next[FLAG_1S_BIT];
    result_next.flag_complete = event_flags_next[FLAG_DONE_BIT];
    result_next.start_pulse   = start_pulse;
    result_next.stop_pulse    = stop_pulse;
    result_next.gate_level    = gate_pin_next;
    result_next.window_state  = gate_state_next;
  end

endmodule

// ===== hw/rtl/tdgw_out.sv =====
// tdgw_out: result register with valid/ready handshake toward the consumer
// frees the input side whenever the register is empty or being drained
// depends on tdgw_pkg
module tdgw_out
  import tdgw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t result_next,
  output logic    can_load,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  assign can_load = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= result_next;
    end
  end

endmodule
